[src/assert_macros.svh]
// Assertion helpers for the two-state Kalman filter block.
// Each check compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KF2_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kf2 implication check failed");
// Next-cycle implication, disabled during reset.
`define KF2_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kf2 next-cycle check failed");
`else
`define KF2_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KF2_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/kf2_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_pkg
// Shared types, constants and fixed-point helpers of the Kalman filter.
// ----------------------------------------------------------------------------
package kf2_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_F  = 3'd0,
        CFG_H  = 3'd1,
        CFG_Q  = 3'd2,
        CFG_R  = 3'd3,
        CFG_X0 = 3'd4,
        CFG_P0 = 3'd5
    } t_cfg_idx;

    // Packed 2x2 identity in Q8.8.
    localparam logic [63:0] IDENT4 = 64'h0100_0000_0000_0100;
    localparam logic signed [15:0] Q_ONE = 16'sd256;

    // Computation phases of one filter step.
    typedef enum logic [10:0] {
        PH_XP  = 11'b000_0000_0001,
        PH_FP  = 11'b000_0000_0010,
        PH_PP  = 11'b000_0000_0100,
        PH_BM  = 11'b000_0000_1000,
        PH_SM  = 11'b000_0001_0000,
        PH_DET = 11'b000_0010_0000,
        PH_KM  = 11'b000_0100_0000,
        PH_KH  = 11'b000_1000_0000,
        PH_NP  = 11'b001_0000_0000,
        PH_HX  = 11'b010_0000_0000,
        PH_KY  = 11'b100_0000_0000
    } t_phase;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b00_0001,
        ST_MAC   = 6'b00_0010,
        ST_DRAIN = 6'b00_0100,
        ST_DIVS  = 6'b00_1000,
        ST_DIVW  = 6'b01_0000,
        ST_DONE  = 6'b10_0000
    } t_state;

    // Destination of one matrix element.
    typedef struct packed {
        t_phase phase;
        logic   row;
        logic   col;
    } t_tag;

    // One multiply-accumulate term.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic sub;
        t_tag tag;
    } t_mac_req;

    // Finished dot product.
    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_mac_rsp;

    // Saturate an 18-bit sum to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Round a Q18.16 sum to Q8.8 with halves up, then saturate.
    function automatic logic signed [15:0] rnd8(input logic signed [33:0] v);
        logic signed [34:0] w;
        logic signed [26:0] s;
        logic signed [15:0] res;
        w = {v[33], v} + 35'sd128;
        s = w[34:8];
        if (s > 27'sd32767) begin
            res = 16'sh7fff;
        end else if (s < -27'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = s[15:0];
        end
        return res;
    endfunction

    // Element i of a packed four-element matrix.
    function automatic logic signed [15:0] el(input logic [63:0] m, input logic [1:0] i);
        return m[{i, 4'b0000} +: 16];
    endfunction

endpackage
`default_nettype wire

[src/kf2_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kf2 channel interfaces
// Measurement, estimate and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface kf2_meas_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] meas_0;
    logic signed [15:0] meas_1;
    modport source (output valid, meas_0, meas_1, input ready);
    modport sink   (input valid, meas_0, meas_1, output ready);
endinterface

interface kf2_est_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] est_0;
    logic signed [15:0] est_1;
    logic               singular;
    modport source (output valid, est_0, est_1, singular, input ready);
    modport sink   (input valid, est_0, est_1, singular, output ready);
endinterface

interface kf2_cfg_if;
    import kf2_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/kf2_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a
// 34-bit accumulator that reports each finished dot product with its tag.
// ----------------------------------------------------------------------------
module kf2_mac (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kf2_pkg::t_mac_req  i_req,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    output kf2_pkg::t_mac_rsp       o_rsp,
    output logic signed [33:0]      o_acc
);
    import kf2_pkg::*;

    t_mac_req           r_req1;
    t_mac_rsp           r_rsp;
    logic signed [31:0] r_prod;
    logic signed [33:0] r_acc;
    logic signed [33:0] w_prod_ext;
    logic signed [33:0] w_base;

    // Control pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req1 <= '0;
            r_rsp  <= '0;
        end else begin
            r_req1      <= i_req;
            r_rsp.valid <= r_req1.valid & r_req1.last;
            r_rsp.tag   <= r_req1.tag;
        end
    end

    assign w_prod_ext = {{2{r_prod[31]}}, r_prod};
    assign w_base     = r_req1.first ? '0 : r_acc;

    // Product register and accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_req1.valid) begin
            r_acc <= r_req1.sub ? (w_base - w_prod_ext) : (w_base + w_prod_ext);
        end
    end

    assign o_rsp = r_rsp;
    assign o_acc = r_acc;

endmodule
`default_nettype wire

[src/kf2_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kf2_div
// Restoring divider for one inverse element: num*65536/den rounded half
// away from zero, clamped and saturated to Q8.8. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module kf2_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [16:0] i_num,
    input  wire logic signed [33:0] i_den,
    output logic                    o_done,
    output logic signed [15:0]      o_quo
);
    localparam int unsigned QW     = 18;
    localparam logic [QW-1:0] QMAX = 18'd40000;

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [34:0]        r_rem;
    logic [51:0]        r_dsh;
    logic [QW-1:0]      r_q;
    logic               r_neg;
    logic               r_ovf;
    logic signed [15:0] r_quo;

    logic [16:0]   w_num_mag;
    logic [33:0]   w_den_mag;
    logic [34:0]   w_rem0;
    logic          w_ge;
    logic [QW-1:0] w_q_next;
    logic [QW-1:0] w_mag;
    logic signed [15:0] w_res;

    assign w_num_mag = i_num[16] ? 17'(-i_num) : 17'(i_num);
    assign w_den_mag = i_den[33] ? 34'(-i_den) : 34'(i_den);
    assign w_rem0    = {1'b0, w_num_mag, 17'd0} + {1'b0, w_den_mag};

    // Current trial subtraction and the quotient after this step.
    assign w_ge     = {17'd0, r_rem} >= r_dsh;
    assign w_q_next = {r_q[QW-2:0], w_ge};

    // Clamp, apply the sign and saturate. A quotient too wide for the
    // quotient register is far above the clamp value.
    always_comb begin
        w_mag = (r_ovf || (w_q_next > QMAX)) ? QMAX : w_q_next;
        if (r_neg) begin
            w_res = (w_mag >= 18'd32768) ? 16'sh8000 : 16'(-w_mag);
        end else begin
            w_res = (w_mag > 18'd32767) ? 16'sh7fff : w_mag[15:0];
        end
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // Datapath: remainder, shifted divisor and quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_rem0;
            r_dsh <= {w_den_mag, 1'b0, 17'd0};
            r_q   <= '0;
            r_neg <= i_num[16] ^ i_den[33];
            r_ovf <= {18'd0, w_rem0} >= {w_den_mag, 19'd0};
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[34:0];
            end
            r_dsh <= {1'b0, r_dsh[51:1]};
            r_q   <= w_q_next;
            if (r_cnt == '0) begin
                r_quo <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

[src/kalman_filter_2x2_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_filter_2x2_unit
// Two-state linear Kalman filter in Q8.8. A small sequencer walks the
// predict, gain and update products through one shared MAC and computes
// the innovation inverse with an iterative divider.
// ----------------------------------------------------------------------------
// Each element accumulates its inner products in the shared MAC, each phase
// ends with a drain of the MAC pipeline, and each inverse element waits on
// the iterative divider.
// Throughput: one measurement at a time; the next is taken once the
// estimate transaction completes. Reset (synchronous, active low) loads
// identity F, H, R, P and zero Q, x, gain; no clearing pass is needed.
`include "assert_macros.svh"
module kalman_filter_2x2_unit #(
    parameter int STATE_DIM = 2,
    parameter int MEAS_DIM  = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kf2_cfg_if.sink   i_cfg,
    kf2_meas_if.sink  i_meas,
    kf2_est_if.source o_est
);
    import kf2_pkg::*;

    localparam int ND = (STATE_DIM > 2) ? 2 : ((STATE_DIM < 1) ? 1 : STATE_DIM);
    localparam int MD = (MEAS_DIM > 2) ? 2 : ((MEAS_DIM < 1) ? 1 : MEAS_DIM);
    localparam logic LN = 1'(ND - 1);
    localparam logic LM = 1'(MD - 1);
    localparam logic [1:0] DIV_LAST = (MD == 2) ? 2'd3 : 2'd0;
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    // Configuration registers.
    logic [63:0] r_f, r_h, r_q, r_r;

    // Filter state and scratch matrices.
    logic signed [15:0] r_est  [2];
    logic signed [15:0] r_cov  [4];
    logic signed [15:0] r_gain [4];
    logic signed [15:0] r_xp   [2];
    logic signed [15:0] r_y    [2];
    logic signed [15:0] r_z    [2];
    logic signed [15:0] r_fp   [4];
    logic signed [15:0] r_pp   [4];
    logic signed [15:0] r_bm   [4];
    logic signed [15:0] r_s    [4];
    logic signed [15:0] r_si   [4];
    logic signed [15:0] r_kh   [4];
    logic signed [33:0] r_det;

    // Sequencer.
    t_state     r_state;
    t_phase     r_phase;
    logic       r_row, r_col, r_k;
    logic [1:0] r_drain;
    logic [1:0] r_dj;
    logic       r_sing;

    logic w_cfg_wr, w_in_acc, w_out_acc;
    logic w_rl, w_cl, w_kl;
    logic [1:0] w_aidx, w_bnt, w_bt, w_widx;
    logic signed [15:0] w_a, w_b;
    logic w_sub;
    t_mac_req w_req;
    t_mac_rsp w_rsp;
    logic signed [33:0] w_acc;
    logic signed [15:0] w_rnd;
    logic w_div_start, w_div_done;
    logic signed [16:0] w_div_num;
    logic signed [15:0] w_quo;
    logic w_fin_sing, w_drain_end;

    assign i_cfg.ready  = 1'b1;
    assign w_cfg_wr     = i_cfg.valid;
    assign i_meas.ready = (r_state == ST_IDLE);
    assign w_in_acc     = i_meas.valid && (r_state == ST_IDLE);
    assign o_est.valid  = (r_state == ST_DONE);
    assign w_out_acc    = o_est.ready && (r_state == ST_DONE);
    assign o_est.est_0  = r_est[0];
    assign o_est.est_1  = (ND == 2) ? r_est[1] : 16'sd0;
    assign o_est.singular = r_sing;

    // Loop bounds of the current phase.
    always_comb begin
        w_rl = LN;
        w_cl = LN;
        w_kl = LN;
        unique case (r_phase)
            PH_XP:  begin w_rl = LN; w_cl = 1'b0; w_kl = LN; end
            PH_FP, PH_PP, PH_NP: begin w_rl = LN; w_cl = LN; w_kl = LN; end
            PH_BM:  begin w_rl = LN; w_cl = LM; w_kl = LN; end
            PH_SM:  begin w_rl = LM; w_cl = LM; w_kl = LN; end
            PH_DET: begin w_rl = 1'b0; w_cl = 1'b0; w_kl = LM; end
            PH_KM:  begin w_rl = LN; w_cl = LM; w_kl = LM; end
            PH_KH:  begin w_rl = LN; w_cl = LN; w_kl = LM; end
            PH_HX:  begin w_rl = LM; w_cl = 1'b0; w_kl = LN; end
            PH_KY:  begin w_rl = LN; w_cl = 1'b0; w_kl = LM; end
            default: begin w_rl = LN; w_cl = LN; w_kl = LN; end
        endcase
    end

    assign w_aidx = {r_row, r_k};
    assign w_bnt  = {r_k, r_col};
    assign w_bt   = {r_col, r_k};

    // Operand selection for the shared MAC.
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        unique case (r_phase)
            PH_XP:  begin w_a = el(r_f, w_aidx);  w_b = r_est[r_k];        end
            PH_FP:  begin w_a = el(r_f, w_aidx);  w_b = r_cov[w_bnt];      end
            PH_PP:  begin w_a = r_fp[w_aidx];     w_b = el(r_f, w_bt);     end
            PH_BM:  begin w_a = r_pp[w_aidx];     w_b = el(r_h, w_bt);     end
            PH_SM:  begin w_a = el(r_h, w_aidx);  w_b = r_bm[w_bnt];       end
            PH_DET: begin
                w_a   = r_k ? r_s[1] : r_s[0];
                w_b   = r_k ? r_s[2] : ((MD == 2) ? r_s[3] : Q_ONE);
                w_sub = r_k;
            end
            PH_KM:  begin w_a = r_bm[w_aidx];     w_b = r_si[w_bnt];       end
            PH_KH:  begin w_a = r_gain[w_aidx];   w_b = el(r_h, w_bnt);    end
            PH_NP:  begin w_a = r_kh[w_aidx];     w_b = r_pp[w_bnt];       end
            PH_HX:  begin w_a = el(r_h, w_aidx);  w_b = r_xp[r_k];         end
            PH_KY:  begin w_a = r_gain[w_aidx];   w_b = r_y[r_k];          end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    always_comb begin
        w_req.valid     = (r_state == ST_MAC);
        w_req.first     = (r_k == 1'b0);
        w_req.last      = (r_k == w_kl);
        w_req.sub       = w_sub;
        w_req.tag.phase = r_phase;
        w_req.tag.row   = r_row;
        w_req.tag.col   = r_col;
    end

    kf2_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_acc   (w_acc)
    );

    // Numerator of the current inverse element.
    always_comb begin
        case (r_dj)
            2'd0:    w_div_num = (MD == 2) ? 17'(r_s[3]) : 17'(Q_ONE);
            2'd1:    w_div_num = -17'(r_s[1]);
            2'd2:    w_div_num = -17'(r_s[2]);
            default: w_div_num = 17'(r_s[0]);
        endcase
    end

    assign w_div_start = (r_state == ST_DIVS);

    kf2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_drain_end = (r_state == ST_DRAIN) && (r_drain == DRAIN_LAST);
    assign w_fin_sing  = w_drain_end && (r_phase == PH_DET) && (r_det == '0);
    assign w_rnd       = rnd8(w_acc);
    assign w_widx      = {w_rsp.tag.row, w_rsp.tag.col};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_XP;
            r_row   <= 1'b0;
            r_col   <= 1'b0;
            r_k     <= 1'b0;
            r_drain <= '0;
            r_dj    <= '0;
            r_sing  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_MAC;
                        r_phase <= PH_XP;
                    end
                end
                ST_MAC: begin
                    if (r_k != w_kl) begin
                        r_k <= 1'b1;
                    end else begin
                        r_k <= 1'b0;
                        if (r_col != w_cl) begin
                            r_col <= 1'b1;
                        end else begin
                            r_col <= 1'b0;
                            if (r_row != w_rl) begin
                                r_row <= 1'b1;
                            end else begin
                                r_row   <= 1'b0;
                                r_drain <= '0;
                                r_state <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    if (r_drain != DRAIN_LAST) begin
                        r_drain <= r_drain + 2'd1;
                    end else begin
                        unique case (r_phase)
                            PH_XP: begin r_phase <= PH_FP; r_state <= ST_MAC; end
                            PH_FP: begin r_phase <= PH_PP; r_state <= ST_MAC; end
                            PH_PP: begin r_phase <= PH_BM; r_state <= ST_MAC; end
                            PH_BM: begin r_phase <= PH_SM; r_state <= ST_MAC; end
                            PH_SM: begin r_phase <= PH_DET; r_state <= ST_MAC; end
                            PH_DET: begin
                                if (r_det == '0) begin
                                    r_sing  <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_dj    <= '0;
                                    r_state <= ST_DIVS;
                                end
                            end
                            PH_KM: begin r_phase <= PH_KH; r_state <= ST_MAC; end
                            PH_KH: begin r_phase <= PH_NP; r_state <= ST_MAC; end
                            PH_NP: begin r_phase <= PH_HX; r_state <= ST_MAC; end
                            PH_HX: begin r_phase <= PH_KY; r_state <= ST_MAC; end
                            PH_KY: begin
                                r_sing  <= 1'b0;
                                r_state <= ST_DONE;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_DIVS: begin
                    r_state <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (w_div_done) begin
                        if (r_dj == DIV_LAST) begin
                            r_phase <= PH_KM;
                            r_state <= ST_MAC;
                        end else begin
                            r_dj    <= r_dj + 2'd1;
                            r_state <= ST_DIVS;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_acc) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Configuration, estimate, covariance and gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f    <= IDENT4;
            r_h    <= IDENT4;
            r_q    <= '0;
            r_r    <= IDENT4;
            r_est  <= '{default: '0};
            for (int i = 0; i < 4; i++) begin
                r_cov[i]  <= el(IDENT4, 2'(i));
                r_gain[i] <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_F: r_f <= i_cfg.data;
                    CFG_H: r_h <= i_cfg.data;
                    CFG_Q: r_q <= i_cfg.data;
                    CFG_R: r_r <= i_cfg.data;
                    CFG_X0: begin
                        r_est[0] <= i_cfg.data[15:0];
                        r_est[1] <= i_cfg.data[31:16];
                    end
                    CFG_P0: begin
                        for (int i = 0; i < 4; i++) begin
                            r_cov[i] <= el(i_cfg.data, 2'(i));
                        end
                    end
                    default: ;
                endcase
            end
            if (w_rsp.valid) begin
                case (w_rsp.tag.phase)
                    PH_KM: r_gain[w_widx] <= w_rnd;
                    PH_NP: r_cov[w_widx]  <= w_rnd;
                    PH_KY: r_est[w_rsp.tag.row] <= sat16(18'(r_xp[w_rsp.tag.row])
                                                         + 18'(w_rnd));
                    default: ;
                endcase
            end
            // Singular innovation: keep the prediction.
            if (w_fin_sing) begin
                r_est[0] <= r_xp[0];
                r_est[1] <= (ND == 2) ? r_xp[1] : 16'sd0;
                for (int i = 0; i < 4; i++) begin
                    r_cov[i] <= r_pp[i];
                end
            end
        end
    end

    // Scratch matrices written back from the MAC, divider and input.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_z[0] <= i_meas.meas_0;
            r_z[1] <= i_meas.meas_1;
        end
        if (w_div_done) begin
            r_si[r_dj] <= w_quo;
        end
        if (w_rsp.valid) begin
            case (w_rsp.tag.phase)
                PH_XP:  r_xp[w_rsp.tag.row] <= w_rnd;
                PH_FP:  r_fp[w_widx] <= w_rnd;
                PH_PP:  r_pp[w_widx] <= sat16(18'(w_rnd) + 18'(el(r_q, w_widx)));
                PH_BM:  r_bm[w_widx] <= w_rnd;
                PH_SM:  r_s[w_widx]  <= sat16(18'(w_rnd) + 18'(el(r_r, w_widx)));
                PH_DET: r_det <= w_acc;
                PH_KH:  r_kh[w_widx] <= sat16(((w_rsp.tag.row == w_rsp.tag.col) ?
                                               18'(Q_ONE) : 18'sd0) - 18'(w_rnd));
                PH_HX:  r_y[w_rsp.tag.row] <= sat16(18'(r_z[w_rsp.tag.row])
                                                    - 18'(w_rnd));
                default: ;
            endcase
        end
    end

    // The divider only ever sees a nonzero determinant.
    `KF2_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIVS, r_det != '0)
    // MAC results only arrive while a phase is issuing or draining.
    `KF2_ASSERT_IMP(a_wb_busy, i_clk, i_rst_n, w_rsp.valid, r_state == ST_MAC || r_state == ST_DRAIN)
    // A finished division always belongs to a waiting sequencer.
    `KF2_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == ST_DIVW)
    // A delivered estimate returns the block to idle.
    `KF2_ASSERT_NXT(a_out_idle, i_clk, i_rst_n, w_out_acc, r_state == ST_IDLE)

endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Kalman filter 2x2 unit testbench
// Drives measurement vectors through the filter under several F, H, Q, R and
// initial-state settings. The expected estimate of each step is computed by
// a predictor inside the scoreboard and compared with every estimate that
// the block returns, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import kf2_pkg::*;

    localparam int N_ITEMS   = 450;
    localparam int LIMIT_CYC = 1500000;
    localparam int DRAIN_CYC = 400;

    logic i_clk;
    logic i_rst_n;

    kf2_cfg_if  cfg_if();
    kf2_meas_if meas_if();
    kf2_est_if  est_if();

    kalman_filter_2x2_unit #(.STATE_DIM(2), .MEAS_DIM(2)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if.sink),
        .i_meas (meas_if.sink),
        .o_est  (est_if.source)
    );

    // One expected estimate transaction.
    typedef struct {
        logic signed [15:0] est_0;
        logic signed [15:0] est_1;
        logic               singular;
    } est_t;

    // Filter predictor and queue of pending estimates.
    class kf_scoreboard;
        logic [63:0] f_reg, h_reg, q_reg, r_reg;
        int          x[2];
        int          p[4];
        est_t        pending[$];
        int          mismatches;

        function new();
            f_reg = IDENT4; h_reg = IDENT4; q_reg = '0; r_reg = IDENT4;
            x[0] = 0; x[1] = 0;
            p[0] = 256; p[1] = 0; p[2] = 0; p[3] = 256;
            mismatches = 0;
        endfunction

        function int sx(logic [63:0] m, int e);
            logic signed [15:0] v;
            v = m[16*e +: 16];
            return int'(v);
        endfunction

        function int sat(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function int round8(longint v);
            longint w;
            w = v + 128;
            return sat(w >>> 8);
        endfunction

        function int recip(longint num, longint den);
            bit      neg;
            longint  n, d, q;
            neg = (num < 0) != (den < 0);
            n = (num < 0 ? -num : num) <<< 16;
            d = den < 0 ? -den : den;
            q = (2 * n + d) / (2 * d);
            if (q > 40000) q = 40000;
            return sat(neg ? -q : q);
        endfunction

        // 2x2 product, optionally with b transposed.
        function void mul2(input int a[4], input int b[4], input bit bt,
                           output int o[4]);
            longint s;
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 2; c++) begin
                    s = 0;
                    for (int k = 0; k < 2; k++)
                        s += longint'(a[r*2+k]) * (bt ? b[c*2+k] : b[k*2+c]);
                    o[r*2+c] = round8(s);
                end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] v);
            case (idx)
                CFG_F: f_reg = v;
                CFG_H: h_reg = v;
                CFG_Q: q_reg = v;
                CFG_R: r_reg = v;
                CFG_X0: for (int e = 0; e < 2; e++) x[e] = sx(v, e);
                CFG_P0: for (int e = 0; e < 4; e++) p[e] = sx(v, e);
                default: ;
            endcase
        endfunction

        // Note one accepted measurement and queue its estimate.
        function void add_meas(logic signed [15:0] z0, logic signed [15:0] z1);
            int f[4], h[4], xv[4], xp[4], fp[4], pp[4], b[4], s[4];
            int si[4], k[4], kh[4], np[4], hx[4], y[4], ky[4];
            longint det;
            est_t e;
            for (int i = 0; i < 4; i++) begin
                f[i] = sx(f_reg, i); h[i] = sx(h_reg, i);
                si[i] = 0; y[i] = 0;
            end
            xv = '{x[0], 0, x[1], 0};
            mul2(f, xv, 0, xp);
            xp[1] = 0; xp[3] = 0;
            mul2(f, p, 0, fp);
            mul2(fp, f, 1, pp);
            for (int i = 0; i < 4; i++) pp[i] = sat(pp[i] + sx(q_reg, i));
            mul2(pp, h, 1, b);
            mul2(h, b, 0, s);
            for (int i = 0; i < 4; i++) s[i] = sat(s[i] + sx(r_reg, i));
            det = longint'(s[0]) * s[3] - longint'(s[1]) * s[2];
            if (det == 0) begin
                x[0] = xp[0]; x[1] = xp[2];
                p = pp;
            end else begin
                si[0] = recip(s[3], det);
                si[1] = recip(-s[1], det);
                si[2] = recip(-s[2], det);
                si[3] = recip(s[0], det);
                mul2(b, si, 0, k);
                mul2(k, h, 0, kh);
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        kh[i*2+j] = sat((i == j ? 256 : 0) - kh[i*2+j]);
                mul2(kh, pp, 0, np);
                p = np;
                mul2(h, xp, 0, hx);
                y[0] = sat(int'(z0) - hx[0]);
                y[2] = sat(int'(z1) - hx[2]);
                mul2(k, y, 0, ky);
                x[0] = sat(xp[0] + ky[0]);
                x[1] = sat(xp[2] + ky[2]);
            end
            e.est_0 = 16'(x[0]); e.est_1 = 16'(x[1]); e.singular = (det == 0);
            pending.push_back(e);
        endfunction

        function void report(string what, int exp_v, int act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, actual %0d", what, exp_v, act_v);
        endfunction

        // Compare one estimate transaction with the oldest expectation.
        function void check_est(logic signed [15:0] e0, logic signed [15:0] e1,
                                logic sg);
            est_t e;
            if (pending.size() == 0) begin
                report("unexpected estimate", 0, 1);
                return;
            end
            e = pending.pop_front();
            if (e.est_0 !== e0) report("est_0", e.est_0, e0);
            if (e.est_1 !== e1) report("est_1", e.est_1, e1);
            if (e.singular !== sg) report("singular", e.singular, sg);
        endfunction
    endclass

    kf_scoreboard sb;
    int           cycles;
    bit           stim_done;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver with its own stall pattern; checks each estimate transaction.
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            est_if.ready <= 1'b0;
        end else begin
            if (est_if.valid && est_if.ready)
                sb.check_est(est_if.est_0, est_if.est_1, est_if.singular);
            case (stall_mode)
                0: est_if.ready <= 1'b1;
                1: est_if.ready <= ($urandom_range(0, 3) != 0);
                default: est_if.ready <= ((cycles % 7) < 2);
            endcase
            if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
        end
    end

    // Write one configuration register, then wait with valid low.
    task automatic write_cfg(t_cfg_idx idx, logic [63:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // Send one measurement transaction; valid stays up for bursts.
    task automatic send_meas(logic [15:0] z0, logic [15:0] z1, bit hold);
        meas_if.valid  <= 1'b1;
        meas_if.meas_0 <= z0;
        meas_if.meas_1 <= z1;
        @(posedge i_clk);
        while (!meas_if.ready) @(posedge i_clk);
        sb.add_meas(z0, z1);
        if (!hold) meas_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Small Q8.8 value for well-behaved matrices.
    function automatic logic [15:0] mild(int lo, int hi);
        return 16'($urandom_range(0, hi - lo) + lo);
    endfunction

    function automatic logic [63:0] mild_mat(int lo, int hi, bit diag_boost);
        logic [63:0] m;
        for (int e = 0; e < 4; e++) m[16*e +: 16] = mild(lo, hi);
        if (diag_boost) begin
            m[15:0]  = m[15:0]  + 16'd256;
            m[63:48] = m[63:48] + 16'd256;
        end
        return m;
    endfunction

    // Random measurement bursts with gaps; valid drops only before a gap or after the last one.
    task automatic run_random(int count);
        int sent, burst, gap;
        bit last, hold;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 40) : 0;
            for (int b = 0; b < burst && sent < count; b++) begin
                last = (b == burst - 1) || (sent + 1 == count);
                hold = !last || (gap == 0 && sent + 1 < count);
                if ($urandom_range(0, 3) == 0)
                    send_meas(rand_elem(), rand_elem(), hold);
                else
                    send_meas(mild(-2048, 2047), mild(-2048, 2047), hold);
                sent++;
            end
            if (gap != 0)
                repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        stim_done = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
        meas_if.valid = 1'b0; meas_if.meas_0 = '0; meas_if.meas_1 = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, field extremes.
        send_meas(16'h0000, 16'h0000, 1);
        send_meas(16'h7fff, 16'h8000, 1);
        send_meas(16'h8000, 16'h7fff, 1);
        send_meas(16'hffff, 16'h0001, 1);
        send_meas(16'h0100, 16'hff00, 0);
        wait_idle();

        // Singular innovation: H and R zero.
        write_cfg(CFG_H, 64'h0);
        write_cfg(CFG_R, 64'h0);
        send_meas(16'h1234, 16'h4321, 1);
        send_meas(16'h7fff, 16'h7fff, 0);
        wait_idle();

        // Extreme registers and state.
        write_cfg(CFG_F, 64'h7fff_8000_8000_7fff);
        write_cfg(CFG_H, 64'hffff_ffff_ffff_ffff);
        write_cfg(CFG_Q, 64'h7fff_7fff_7fff_7fff);
        write_cfg(CFG_R, 64'h8000_0000_0000_8000);
        write_cfg(CFG_X0, 64'h0000_0000_7fff_8000);
        write_cfg(CFG_P0, 64'h8000_7fff_7fff_8000);
        send_meas(16'h7fff, 16'h8000, 1);
        send_meas(16'h0000, 16'hffff, 1);
        send_meas(16'h8000, 16'h8000, 0);
        wait_idle();

        // Unknown register index is ignored by the block.
        write_cfg(t_cfg_idx'(3'd7), 64'hdead_beef_dead_beef);
        write_cfg(t_cfg_idx'(3'd6), 64'h0123_4567_89ab_cdef);
        send_meas(16'h0042, 16'hff80, 0);
        wait_idle();

        // Random phases over several settings.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                write_cfg(CFG_F, {4{16'($urandom)}} ^ 64'($urandom) << 32 ^ 64'($urandom));
                write_cfg(CFG_H, {32'($urandom), 32'($urandom)});
                write_cfg(CFG_Q, {32'($urandom), 32'($urandom)});
                write_cfg(CFG_R, {32'($urandom), 32'($urandom)});
                write_cfg(CFG_X0, {32'h0, 32'($urandom)});
                write_cfg(CFG_P0, {32'($urandom), 32'($urandom)});
            end else begin
                write_cfg(CFG_F, mild_mat(-64, 64, 1));
                write_cfg(CFG_H, mild_mat(-128, 128, 1));
                write_cfg(CFG_Q, mild_mat(0, 32, 0));
                write_cfg(CFG_R, mild_mat(0, 64, 1));
                write_cfg(CFG_X0, {32'h0, mild(-4096, 4096), mild(-4096, 4096)});
                write_cfg(CFG_P0, mild_mat(-32, 32, 1));
            end
            run_random(N_ITEMS / 6);
            // Hold off until every expected estimate has come.
            if (ph == 2) wait_idle();
            wait_idle();
        end

        stim_done = 1;
        wait_idle();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
